// File: rtl/ssid_pkg.sv
// ssid_pkg: shared types, codes and defaults for the sorted set block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssid_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VAL_W        = 32;
	localparam int CNT_OUT_W    = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_DUMP      = 3'd5;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic signed [VAL_W-1:0] entry_value;
		logic                    entry_valid;
		logic [CNT_OUT_W-1:0]    stored_count;
		logic                    last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic update;
		logic dump_emit;
		logic dump_empty;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       count_zero;
		logic       dump_last;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/sorted_set_insert_delete_top.sv
// sorted_set_insert_delete_top: sorted set with insert, delete and dump.
// Depends on ssid_pkg, ssid_ctrl, ssid_datapath.
//
//  port     dir  kind              transfer when
//  request  in   req_t command     start && !busy
//  result   out  rsp_t result      done (one cycle, no backpressure)
//
// Insert/delete: accepted, compared in all cells in the next cycle, result
// in the cycle after; a new command can be taken while that result shows.
// Dump: one result per entry, one entry per cycle from the rotating cell array.
// Empty dump: one result, no entry. Reset clears the count, no clearing pass.
`default_nettype none

module sorted_set_insert_delete_top import ssid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  req_t  request,
	output logic  busy,
	output logic  done,
	output rsp_t  result
);

	ctl_t ctl;
	sts_t sts;
	logic ctrl_busy;

	ssid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (ctrl_busy),
		.ctl    (ctl)
	);

	ssid_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

	assign busy = ctrl_busy;

endmodule

`default_nettype wire

// File: rtl/ssid_datapath.sv
// ssid_datapath: sorted shift-register cell array, entry count, dump counter
// and result register. Depends on ssid_pkg; driven by ssid_ctrl.
`default_nettype none

module ssid_datapath import ssid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  req_t        request,
	input  ctl_t        ctl,
	output sts_t        sts,
	output logic        done,
	output rsp_t        result
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [VAL_W-1:0] cells_q [CAPACITY];
	logic signed [VAL_W-1:0] cell_d  [CAPACITY];
	logic [CAPACITY-1:0]     cell_we;
	logic [CAPACITY-1:0]     vld, lt, eq;

	logic [1:0]              op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           count_q, cnt_d, last_idx, dcnt_q;
	logic                    found, full, do_ins, do_del, dump_last;
	logic                    done_q;
	rsp_t                    rsp_q;

	// per-cell compare against the held value
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			vld[i] = CW'(i) < count_q;
			lt[i]  = vld[i] && (cells_q[i] < val_q);
			eq[i]  = vld[i] && (cells_q[i] == val_q);
		end
	end

	assign found     = |eq;
	assign full      = count_q == CW'(CAPACITY);
	assign do_ins    = ctl.update && (op_q == OP_INSERT) && !found && !full;
	assign do_del    = ctl.update && (op_q == OP_DELETE) && found;
	assign last_idx  = count_q - CW'(1);
	assign dump_last = dcnt_q == last_idx;

	always_comb begin
		if (do_ins)
			cnt_d = count_q + CW'(1);
		else if (do_del)
			cnt_d = count_q - CW'(1);
		else
			cnt_d = count_q;
	end

	genvar g;
	for (g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VAL_W-1:0] ins_w, next_w, rot_w;
		if (g == 0) begin : g_first
			assign ins_w = val_q;
		end else begin : g_rest
			assign ins_w = lt[g-1] ? val_q : cells_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_top
			assign next_w = cells_q[0];
		end else begin : g_mid
			assign next_w = cells_q[g+1];
		end
		// rotate the occupied cells down by one per dump beat
		assign rot_w = (last_idx == CW'(g)) ? cells_q[0] : next_w;

		always_comb begin
			cell_we[g] = 1'b0;
			cell_d[g]  = rot_w;
			if (do_ins && !lt[g]) begin
				cell_we[g] = 1'b1;
				cell_d[g]  = ins_w;
			end else if (do_del && !lt[g]) begin
				cell_we[g] = 1'b1;
				cell_d[g]  = next_w;
			end else if (ctl.dump_emit) begin
				cell_we[g] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_we[i])
				cells_q[i] <= cell_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= request.operation;
			val_q <= request.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cnt_d;
			done_q  <= ctl.update | ctl.dump_emit | ctl.dump_empty;
			if (ctl.load)
				dcnt_q <= '0;
			else if (ctl.dump_emit)
				dcnt_q <= dcnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			if (op_q == OP_INSERT)
				rsp_q.status <= found ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
			else
				rsp_q.status <= found ? ST_DELETED : ST_NOT_FOUND;
			rsp_q.entry_value  <= val_q;
			rsp_q.entry_valid  <= 1'b0;
			rsp_q.stored_count <= CNT_OUT_W'(cnt_d);
			rsp_q.last         <= 1'b1;
		end else if (ctl.dump_emit) begin
			rsp_q.status       <= ST_DUMP;
			rsp_q.entry_value  <= cells_q[0];
			rsp_q.entry_valid  <= 1'b1;
			rsp_q.stored_count <= CNT_OUT_W'(count_q);
			rsp_q.last         <= dump_last;
		end else if (ctl.dump_empty) begin
			rsp_q.status       <= ST_DUMP;
			rsp_q.entry_value  <= '0;
			rsp_q.entry_valid  <= 1'b0;
			rsp_q.stored_count <= CNT_OUT_W'(count_q);
			rsp_q.last         <= 1'b1;
		end
	end

	assign sts.op         = op_q;
	assign sts.count_zero = count_q == '0;
	assign sts.dump_last  = dump_last;
	assign done           = done_q;
	assign result         = rsp_q;

endmodule

`default_nettype wire

// File: rtl/ssid_ctrl.sv
// ssid_ctrl: operation sequencer (idle, evaluate, dump beats).
// Depends on ssid_pkg; commands ssid_datapath.
`default_nettype none

module ssid_ctrl import ssid_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  sts_t  sts,
	output logic  busy,
	output ctl_t  ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_IDLE;
				if (sts.op inside {OP_INSERT, OP_DELETE}) begin
					ctl.update = 1'b1;
				end else if (sts.op == OP_DUMP) begin
					if (sts.count_zero)
						ctl.dump_empty = 1'b1;
					else
						state_d = S_DUMP;
				end
			end
			S_DUMP: begin
				ctl.dump_emit = 1'b1;
				if (sts.dump_last)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

// File: rtl/ssid_checker.sv
// ssid_checker: port-level assertions for sorted_set_insert_delete_top.
// Depends on ssid_pkg; attached by the bind at the end of this file.
`default_nettype none

module ssid_checker import ssid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire  clk,
	input wire  arst_n,
	input wire  start,
	input wire  busy,
	input wire  done,
	input rsp_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted command");

	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |=> done && result.status == ST_DUMP)
		else $error("dump burst broken before last entry");

	a_busy_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy)
		else $error("command could be taken mid dump");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.stored_count <= CNT_OUT_W'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_valid_dump: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.entry_valid |-> result.status == ST_DUMP)
		else $error("entry_valid outside dump");

endmodule

bind sorted_set_insert_delete_top ssid_checker #(.CAPACITY(CAPACITY)) u_ssid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

`default_nettype wire
